[rtl/core/gsi_pkg.sv]
// Shared widths, defaults and divider request/response types for the
// Gouraud span interpolator. No dependencies.
`timescale 1ns / 1ps

package gsi_pkg;

	localparam int DEF_SCREEN_WIDTH = 512;
	localparam int DEF_ROW_COUNT    = 512;
	localparam int DEF_LANES        = 8;

	localparam int ROW_W       = 9;
	localparam int X_W         = 9;
	localparam int LEVEL_W     = 16;
	localparam int VCNT_W      = 4;
	localparam int OUT_LANES   = 8;
	localparam int FRAC_W      = 16;
	localparam int QUO_W       = 32;   // |level diff| << 16
	localparam int ACC_W       = 38;   // signed accumulator, holds 8 x step
	localparam int MAX_RESULTS = 64;
	localparam int RCNT_W      = 6;

	typedef logic [OUT_LANES-1:0][LEVEL_W-1:0] level_vec_t;

	typedef struct packed {
		logic             start;
		logic [QUO_W-1:0] dividend;
		logic [X_W-1:0]   divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [QUO_W-1:0] quotient;
	} div_rsp_t;

endpackage

[rtl/core/gsi_ifs.sv]
// Valid/ready channel interfaces: span in, pixel group out.
// Depends on gsi_pkg.
`timescale 1ns / 1ps

interface gsi_span_if;
	import gsi_pkg::*;
	logic               valid;
	logic               ready;
	logic [ROW_W-1:0]   row;
	logic [X_W-1:0]     x_a;
	logic [X_W-1:0]     x_b;
	logic [LEVEL_W-1:0] level_a;
	logic [LEVEL_W-1:0] level_b;

	modport source (output valid, row, x_a, x_b, level_a, level_b, input ready);
	modport sink   (input valid, row, x_a, x_b, level_a, level_b, output ready);
endinterface

interface gsi_pix_if;
	import gsi_pkg::*;
	logic               valid;
	logic               ready;
	logic [ROW_W-1:0]   out_row;
	logic [X_W-1:0]     x_start;
	logic [VCNT_W-1:0]  valid_count;
	logic               last;
	logic [LEVEL_W-1:0] level_0;
	logic [LEVEL_W-1:0] level_1;
	logic [LEVEL_W-1:0] level_2;
	logic [LEVEL_W-1:0] level_3;
	logic [LEVEL_W-1:0] level_4;
	logic [LEVEL_W-1:0] level_5;
	logic [LEVEL_W-1:0] level_6;
	logic [LEVEL_W-1:0] level_7;

	modport source (output valid, out_row, x_start, valid_count, last,
		level_0, level_1, level_2, level_3, level_4, level_5, level_6, level_7,
		input ready);
	modport sink   (input valid, out_row, x_start, valid_count, last,
		level_0, level_1, level_2, level_3, level_4, level_5, level_6, level_7,
		output ready);
endinterface

[rtl/core/gsi_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on gsi_pkg.
`timescale 1ns / 1ps

module gsi_div (
	input  logic              clk,
	input  logic              arst_n,
	input  gsi_pkg::div_req_t req,
	output gsi_pkg::div_rsp_t rsp
);
	import gsi_pkg::*;

	localparam int CNT_W = $clog2(QUO_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [QUO_W-1:0] quo_q;
	logic [X_W-1:0]   rem_q;
	logic [X_W-1:0]   div_q;

	logic [X_W:0]     trial;
	logic [X_W:0]     trial_sub;
	logic             ge;
	logic [X_W-1:0]   rem_next;

	assign trial     = {rem_q, quo_q[QUO_W-1]};
	assign trial_sub = trial - {1'b0, div_q};
	assign ge        = trial >= {1'b0, div_q};
	// trial < 2*divisor, so both outcomes fit the remainder width
	assign rem_next  = ge ? trial_sub[X_W-1:0] : trial[X_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(QUO_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			div_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("divider restarted while busy");
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !req.start && cnt_q == CNT_W'(QUO_W - 1)) |=> (done_q && !busy_q))
		else $error("divider did not finish after full bit count");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("divider done held longer than one cycle");

endmodule

[rtl/core/gsi_lanes.sv]
// Per-lane intensity: base plus lane offset, floor the 16.16 sum to its integer level, clamp.
// Depends on gsi_pkg.
`timescale 1ns / 1ps

module gsi_lanes #(
	parameter int LANES = gsi_pkg::DEF_LANES
) (
	input  logic signed [gsi_pkg::ACC_W-1:0]  base,
	input  logic signed [gsi_pkg::ACC_W-1:0]  offs [LANES+1],
	input  logic        [gsi_pkg::VCNT_W-1:0] valid_count,
	output gsi_pkg::level_vec_t               levels
);
	import gsi_pkg::*;

	logic signed [ACC_W-1:0] sum_w [OUT_LANES];

	function automatic logic [LEVEL_W-1:0] level_of(input logic signed [ACC_W-1:0] a);
		logic [LEVEL_W-1:0] v;
		if (a < 0)
			v = '0;
		else if (a[ACC_W-2:FRAC_W+LEVEL_W] != '0)
			v = '1;
		else
			v = a[FRAC_W+LEVEL_W-1:FRAC_W];
		return v;
	endfunction

	for (genvar i = 0; i < OUT_LANES; i++) begin : g_lane
		if (i < LANES) begin : g_used
			assign sum_w[i] = base + offs[i];
		end else begin : g_unused
			assign sum_w[i] = '0;
		end
	end

	always_comb begin
		for (int i = 0; i < OUT_LANES; i++) begin
			if (i < LANES && VCNT_W'(i) < valid_count)
				levels[i] = level_of(sum_w[i]);
			else
				levels[i] = '0;
		end
	end

endmodule

[rtl/core/gouraud_span_interpolator.sv]
// Top level of the Gouraud span interpolator: sequencer, step table,
// output register. Depends on gsi_pkg, gsi_ifs, gsi_div, gsi_lanes.
`timescale 1ns / 1ps

// Channel   Dir  Handshake      Carries
// span      in   valid/ready    row, x_a, x_b, level_a, level_b
// pixels    out  valid/ready    out_row, x_start, valid_count, last, level_0..7
//
// One span at a time. A span wider than one pixel then runs through the
// divider (one quotient bit per cycle over 32 bits, launched from S_START
// and handed back in S_DIV). The lane offset table is then built with one
// adder in S_TABLE. Groups then leave one per cycle while the sink is
// ready: ceil(n/LANES) of them, at most 64. Reset is asynchronous and
// leaves the block idle and ready; a stalled sink holds the output register
// and the sequencer, and span.ready is high only while idle.

module gouraud_span_interpolator #(
	parameter int SCREEN_WIDTH = gsi_pkg::DEF_SCREEN_WIDTH,
	parameter int ROW_COUNT    = gsi_pkg::DEF_ROW_COUNT,
	parameter int LANES        = gsi_pkg::DEF_LANES
) (
	input logic     clk,
	input logic     arst_n,
	gsi_span_if.sink  span,
	gsi_pix_if.source pixels
);
	import gsi_pkg::*;

	localparam int IDX_W = $clog2(LANES + 1);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_START = 5'b00010,
		S_DIV   = 5'b00100,
		S_TABLE = 5'b01000,
		S_EMIT  = 5'b10000
	} state_t;

	state_t state_q;

	// span registers
	logic [ROW_W-1:0]   row_q;
	logic [X_W-1:0]     xmin_q;
	logic [X_W-1:0]     xmax_q;
	logic [LEVEL_W-1:0] imin_q;
	logic [LEVEL_W-1:0] imax_q;
	logic               neg_q;

	// step and lane offset table: offs_q[i] = i * step
	logic signed [ACC_W-1:0] step_q;
	logic signed [ACC_W-1:0] run_q;
	logic signed [ACC_W-1:0] offs_q [LANES+1];
	logic [IDX_W-1:0]        idx_q;

	// emission
	logic signed [ACC_W-1:0] base_q;
	logic [X_W:0]            cur_x_q;
	logic [RCNT_W-1:0]       rcnt_q;

	// output register
	logic               out_valid_q;
	logic [ROW_W-1:0]   out_row_q;
	logic [X_W-1:0]     x_start_q;
	logic [VCNT_W-1:0]  vcnt_q;
	logic               last_q;
	level_vec_t         level_q;

	// accept path: clamp x to screen, order endpoints
	logic               in_acc;
	logic               row_ok;
	logic [X_W-1:0]     xa_c;
	logic [X_W-1:0]     xb_c;
	logic               a_first;

	assign span.ready = (state_q == S_IDLE);
	assign in_acc     = span.valid && span.ready;
	assign row_ok     = 32'(span.row) < 32'(ROW_COUNT);
	assign xa_c       = (32'(span.x_a) >= 32'(SCREEN_WIDTH)) ? X_W'(SCREEN_WIDTH - 1) : span.x_a;
	assign xb_c       = (32'(span.x_b) >= 32'(SCREEN_WIDTH)) ? X_W'(SCREEN_WIDTH - 1) : span.x_b;
	assign a_first    = xa_c < xb_c;

	// divider operands
	logic [LEVEL_W:0]   diff;
	logic [LEVEL_W-1:0] mag;
	div_req_t           div_req;
	div_rsp_t           div_rsp;
	logic signed [ACC_W-1:0] quo_ext;

	assign diff = {1'b0, imax_q} - {1'b0, imin_q};
	assign mag  = diff[LEVEL_W] ? LEVEL_W'(-diff) : diff[LEVEL_W-1:0];

	assign div_req.start    = (state_q == S_START);
	assign div_req.dividend = {mag, {FRAC_W{1'b0}}};
	assign div_req.divisor  = xmax_q - xmin_q;

	assign quo_ext = ACC_W'(div_rsp.quotient);

	gsi_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// group framing
	logic [X_W:0]        remaining;
	logic [VCNT_W-1:0]   vcnt;
	logic                grp_last;
	logic                load;
	level_vec_t          lane_levels;

	assign remaining = {1'b0, xmax_q} + 1'b1 - cur_x_q;
	assign vcnt      = (remaining < (X_W+1)'(LANES)) ? VCNT_W'(remaining) : VCNT_W'(LANES);
	assign grp_last  = (remaining <= (X_W+1)'(LANES)) ||
		(rcnt_q == RCNT_W'(MAX_RESULTS - 1));
	assign load      = (state_q == S_EMIT) && (!out_valid_q || pixels.ready);

	gsi_lanes #(.LANES(LANES)) u_lanes (
		.base        (base_q),
		.offs        (offs_q),
		.valid_count (vcnt),
		.levels      (lane_levels)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc && row_ok)
						state_q <= (xa_c != xb_c) ? S_START : S_TABLE;
				end
				S_START: state_q <= S_DIV;
				S_DIV: begin
					if (div_rsp.done)
						state_q <= S_TABLE;
				end
				S_TABLE: begin
					if (idx_q == IDX_W'(LANES - 1))
						state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (load && grp_last)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				row_q  <= span.row;
				xmin_q <= a_first ? xa_c : xb_c;
				xmax_q <= a_first ? xb_c : xa_c;
				imin_q <= a_first ? span.level_a : span.level_b;
				imax_q <= a_first ? span.level_b : span.level_a;
				step_q <= '0;
				run_q  <= '0;
				idx_q  <= '0;
				offs_q[0] <= '0;
			end
			S_START: neg_q <= diff[LEVEL_W];
			S_DIV: begin
				if (div_rsp.done)
					step_q <= neg_q ? -quo_ext : quo_ext;
			end
			S_TABLE: begin
				run_q              <= run_q + step_q;
				offs_q[idx_q + 1'b1] <= run_q + step_q;
				idx_q              <= idx_q + 1'b1;
				base_q             <= ACC_W'({imin_q, {FRAC_W{1'b0}}});
				cur_x_q            <= {1'b0, xmin_q};
				rcnt_q             <= '0;
			end
			S_EMIT: begin
				if (load) begin
					base_q  <= base_q + offs_q[LANES];
					cur_x_q <= cur_x_q + (X_W+1)'(LANES);
					rcnt_q  <= rcnt_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load)
			out_valid_q <= 1'b1;
		else if (pixels.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_row_q <= row_q;
			x_start_q <= cur_x_q[X_W-1:0];
			vcnt_q    <= vcnt;
			last_q    <= grp_last;
			level_q   <= lane_levels;
		end
	end

	assign pixels.valid       = out_valid_q;
	assign pixels.out_row     = out_row_q;
	assign pixels.x_start     = x_start_q;
	assign pixels.valid_count = vcnt_q;
	assign pixels.last        = last_q;
	assign pixels.level_0     = level_q[0];
	assign pixels.level_1     = level_q[1];
	assign pixels.level_2     = level_q[2];
	assign pixels.level_3     = level_q[3];
	assign pixels.level_4     = level_q[4];
	assign pixels.level_5     = level_q[5];
	assign pixels.level_6     = level_q[6];
	assign pixels.level_7     = level_q[7];

	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_DIV))
		else $error("divider result outside the divide phase");
	a_table_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) |-> (offs_q[1] == step_q && offs_q[0] == '0))
		else $error("lane offset table does not match step");
	a_x_in_span: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) |-> (cur_x_q <= {1'b0, xmax_q} && cur_x_q >= {1'b0, xmin_q}))
		else $error("group start outside span");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(load && grp_last) |=> (state_q == S_IDLE && out_valid_q && last_q))
		else $error("final group did not close the span");

endmodule

[dv/gsi_span_checker.sv]
`timescale 1ns / 1ps
// Span checker: predicts the pixel groups of each span the block takes in and
// compares them with the groups it sends out. Depends on gsi_pkg and gsi_ifs.

module gsi_span_checker #(
	parameter int SCREEN_WIDTH = gsi_pkg::DEF_SCREEN_WIDTH,
	parameter int ROW_COUNT    = gsi_pkg::DEF_ROW_COUNT,
	parameter int LANES        = gsi_pkg::DEF_LANES
) (
	input  logic        clk,
	input  logic        arst_n,
	gsi_span_if         span_mon,
	gsi_pix_if          pix_mon,
	output int unsigned fail_count,
	output int unsigned groups_pending
);
	import gsi_pkg::*;

	localparam int LANE_N = (LANES < 1) ? 1 : (LANES > OUT_LANES) ? OUT_LANES : LANES;
	localparam longint LEVEL_MAX = (64'sd1 <<< LEVEL_W) - 1;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic [ROW_W-1:0]  row;
		logic [X_W-1:0]    x_start;
		logic [VCNT_W-1:0] count;
		logic              last;
		level_vec_t        levels;
	} pix_group_t;

	pix_group_t expected_groups[$];

	// floor the 16.16 value to its integer part, then clamp to the unsigned level range
	function automatic logic [LEVEL_W-1:0] level_of_acc(input longint acc);
		longint whole;
		if (acc < 0)
			return '0;
		whole = acc >>> FRAC_W;
		if (whole > LEVEL_MAX)
			whole = LEVEL_MAX;
		return whole[LEVEL_W-1:0];
	endfunction

	function automatic int clamp_x(input logic [X_W-1:0] x);
		return (int'(x) >= SCREEN_WIDTH) ? SCREEN_WIDTH - 1 : int'(x);
	endfunction

	function automatic void predict_span(input logic [ROW_W-1:0] row,
			input logic [X_W-1:0] x_a, input logic [X_W-1:0] x_b,
			input logic [LEVEL_W-1:0] level_a, input logic [LEVEL_W-1:0] level_b);
		int         xa, xb, xmin, xmax, x, lanes_now, n_groups;
		longint     imin, imax, step, acc;
		pix_group_t grp;
		if (int'(row) >= ROW_COUNT)
			return;
		xa = clamp_x(x_a);
		xb = clamp_x(x_b);
		// equal x goes the reversed way: endpoint b starts
		if (xa < xb) begin
			xmin = xa; xmax = xb; imin = longint'(level_a); imax = longint'(level_b);
		end else begin
			xmin = xb; xmax = xa; imin = longint'(level_b); imax = longint'(level_a);
		end
		step = 0;
		if (xmax > xmin)
			step = ((imax - imin) <<< FRAC_W) / longint'(xmax - xmin);
		acc = imin <<< FRAC_W;
		x = xmin;
		n_groups = 0;
		while (x <= xmax && n_groups < MAX_RESULTS) begin
			lanes_now = (xmax - x + 1 < LANE_N) ? xmax - x + 1 : LANE_N;
			grp = '0;
			grp.row = row;
			grp.x_start = x[X_W-1:0];
			grp.count = lanes_now[VCNT_W-1:0];
			for (int i = 0; i < lanes_now; i++) begin
				grp.levels[i] = level_of_acc(acc);
				acc += step;
			end
			x += lanes_now;
			n_groups++;
			grp.last = (x > xmax) || (n_groups == MAX_RESULTS);
			expected_groups = {expected_groups, grp};
		end
	endfunction

	function automatic void note_mismatch(input string what, input int unsigned want,
			input int unsigned got);
		fail_count++;
		if (fail_count <= REPORT_LIMIT)
			$display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
	endfunction

	function automatic void check_group();
		pix_group_t want, got;
		string      ctx;
		got.row     = pix_mon.out_row;
		got.x_start = pix_mon.x_start;
		got.count   = pix_mon.valid_count;
		got.last    = pix_mon.last;
		got.levels  = {pix_mon.level_7, pix_mon.level_6, pix_mon.level_5, pix_mon.level_4,
			pix_mon.level_3, pix_mon.level_2, pix_mon.level_1, pix_mon.level_0};
		if (expected_groups.size() == 0) begin
			fail_count++;
			if (fail_count <= REPORT_LIMIT)
				$display("%0t: pixel group row %0d x %0d arrived with none outstanding",
					$time, got.row, got.x_start);
			return;
		end
		want = expected_groups.pop_front();
		ctx = $sformatf("group row %0d x %0d", want.row, want.x_start);
		if (got.row != want.row)
			note_mismatch({ctx, " out_row"}, 32'(want.row), 32'(got.row));
		if (got.x_start != want.x_start)
			note_mismatch({ctx, " x_start"}, 32'(want.x_start), 32'(got.x_start));
		if (got.count != want.count)
			note_mismatch({ctx, " valid_count"}, 32'(want.count), 32'(got.count));
		if (got.last != want.last)
			note_mismatch({ctx, " last"}, 32'(want.last), 32'(got.last));
		for (int i = 0; i < OUT_LANES; i++) begin
			if (got.levels[i] != want.levels[i])
				note_mismatch({ctx, $sformatf(" level_%0d", i)}, 32'(want.levels[i]),
					32'(got.levels[i]));
		end
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			expected_groups.delete();
			fail_count = 0;
			groups_pending <= 0;
		end else begin
			if (span_mon.valid && span_mon.ready)
				predict_span(span_mon.row, span_mon.x_a, span_mon.x_b,
					span_mon.level_a, span_mon.level_b);
			if (pix_mon.valid && pix_mon.ready)
				check_group();
			groups_pending <= expected_groups.size();
		end
	end

endmodule

[dv/gouraud_span_interpolator_tb.sv]
`timescale 1ns / 1ps
// Top of the span interpolator testbench: clock, reset, span stimulus, pixel
// sink and verdict. Depends on gsi_pkg, gsi_ifs, gsi_span_checker and the RTL.

module gouraud_span_interpolator_tb;
	import gsi_pkg::*;

	localparam int SCREEN_WIDTH     = DEF_SCREEN_WIDTH;
	localparam int ROW_COUNT        = DEF_ROW_COUNT;
	localparam int LANES            = DEF_LANES;
	localparam int RANDOM_PER_PHASE = 131;  // three phases, plus the directed spans
	localparam int LONG_HOLD        = 400;  // sink hold-off, in cycles
	localparam int TAIL_CYCLES      = 150;  // margin beyond the worst span
	// no transaction for this long means the block has hung; the longest
	// honest gap is the sink hold-off plus one divide and table build
	localparam int WATCHDOG_LIMIT   = 3000;

	logic clk = 1'b0;
	logic arst_n;

	gsi_span_if span ();
	gsi_pix_if  pixels ();

	int unsigned fail_count;
	int unsigned groups_pending;
	int unsigned src_idle_pct;   // chance per cycle that the span side idles
	int unsigned sink_idle_pct;  // chance per cycle that the pixel side stalls
	int unsigned holds_asked;    // bumped by the stimulus to ask for a long stall
	int unsigned holds_done;
	int unsigned quiet_cycles;

	always #6 clk = ~clk;

	gouraud_span_interpolator #(
		.SCREEN_WIDTH(SCREEN_WIDTH),
		.ROW_COUNT(ROW_COUNT),
		.LANES(LANES)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.span(span),
		.pixels(pixels)
	);

	gsi_span_checker #(
		.SCREEN_WIDTH(SCREEN_WIDTH),
		.ROW_COUNT(ROW_COUNT),
		.LANES(LANES)
	) u_check (
		.clk(clk),
		.arst_n(arst_n),
		.span_mon(span),
		.pix_mon(pixels),
		.fail_count(fail_count),
		.groups_pending(groups_pending)
	);

	// Offer one span, idling first at random, and return at the edge where
	// the transaction completes. valid stays high into the next call, so
	// back-to-back spans never see it dropped and raised in one step.
	task automatic send_span(input logic [ROW_W-1:0] row,
			input logic [X_W-1:0] x_a, input logic [X_W-1:0] x_b,
			input logic [LEVEL_W-1:0] level_a, input logic [LEVEL_W-1:0] level_b);
		while ($urandom_range(99) < src_idle_pct) begin
			span.valid <= 1'b0;
			@(posedge clk);
		end
		span.valid   <= 1'b1;
		span.row     <= row;
		span.x_a     <= x_a;
		span.x_b     <= x_b;
		span.level_a <= level_a;
		span.level_b <= level_b;
		do @(posedge clk); while (!span.ready);
	endtask

	// Mostly short spans so that the run stays quick; about a quarter reach
	// across any part of the line, up to the full 512 pixels (64 groups).
	task automatic send_random_span();
		int unsigned        width, base, pick;
		logic [X_W-1:0]     x_a, x_b;
		logic [LEVEL_W-1:0] level_a, level_b;
		pick = $urandom_range(99);
		if (pick < 45)
			width = $urandom_range(17);
		else if (pick < 75)
			width = $urandom_range(80);
		else
			width = $urandom_range(SCREEN_WIDTH - 1);
		base = $urandom_range(SCREEN_WIDTH - 1 - width);
		// either endpoint may be the left one
		if ($urandom_range(1)) begin
			x_a = X_W'(base);
			x_b = X_W'(base + width);
		end else begin
			x_a = X_W'(base + width);
			x_b = X_W'(base);
		end
		level_a = LEVEL_W'($urandom);
		level_b = LEVEL_W'($urandom);
		pick = $urandom_range(99);
		if (pick < 10) begin
			level_b = level_a;                  // flat span, zero step
		end else if (pick < 20) begin
			level_a = {LEVEL_W{pick[0]}};       // full-scale ramp up or down
			level_b = ~level_a;
		end
		send_span(ROW_W'($urandom), x_a, x_b, level_a, level_b);
	endtask

	// Pixel side: random stalls at the phase's rate, and on request one long
	// hold-off so that a span sits stalled in the block while the span side
	// keeps offering the next one.
	initial begin : pixel_sink
		pixels.ready = 1'b0;
		holds_done   = 0;
		forever begin
			@(posedge clk);
			if (holds_done != holds_asked) begin
				holds_done = holds_asked;
				repeat (LONG_HOLD) begin
					pixels.ready <= 1'b0;
					@(posedge clk);
				end
			end
			pixels.ready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	// Watchdog: counts cycles in which neither channel completes a transaction.
	always @(posedge clk) begin
		if (!arst_n || (span.valid && span.ready) || (pixels.valid && pixels.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : stimulus
		arst_n        = 1'b0;
		span.valid    = 1'b0;
		span.row      = '0;
		span.x_a      = '0;
		span.x_b      = '0;
		span.level_a  = '0;
		span.level_b  = '0;
		src_idle_pct  = 32;
		sink_idle_pct = 70;
		holds_asked   = 0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed spans, run under the first phase's idling.
		send_span(9'd0,   9'd0,   9'd511, 16'h0000, 16'hFFFF);  // full line, 64 groups
		send_span(9'd511, 9'd511, 9'd0,   16'h0000, 16'hFFFF);  // full line, b starts
		send_span(9'd17,  9'd100, 9'd100, 16'h0001, 16'hFFFF);  // equal x: b's level
		send_span(9'h155, 9'd0,   9'd0,   16'hFFFF, 16'h0000);  // one pixel, left edge
		send_span(9'h0AA, 9'd511, 9'd511, 16'h1234, 16'hABCD);  // one pixel, right edge
		send_span(9'd3,   9'd10,  9'd17,  16'h0100, 16'h0900);  // exactly one full group
		send_span(9'd4,   9'd10,  9'd18,  16'h0900, 16'h0100);  // one lane spills over
		send_span(9'd5,   9'd20,  9'd26,  16'hFFFF, 16'hFFFF);  // seven lanes, flat max
		send_span(9'd6,   9'd40,  9'd41,  16'h0000, 16'hFFFF);  // two pixels, big step
		send_span(9'd7,   9'd41,  9'd40,  16'h0000, 16'hFFFF);  // same, reversed
		send_span(9'd8,   9'd0,   9'd3,   16'h0000, 16'h0001);  // tiny rising step
		send_span(9'd9,   9'd0,   9'd3,   16'h0001, 16'h0000);  // tiny falling step
		send_span(9'd10,  9'd500, 9'd511, 16'h8000, 16'h7FFF);  // short tail at the edge
		send_span(9'h1FF, 9'd0,   9'd255, 16'hFFFF, 16'h0000);  // long falling ramp
		send_span(9'd256, 9'h1FF, 9'h100, 16'h00FF, 16'hFF00);  // reversed, mixed bits
		send_span(9'd1,   9'd300, 9'd299, 16'h0000, 16'h0000);  // all dark

		// Random spans in three phases of idling; the long sink hold-off is
		// asked once with the span side idling and once with it never idle.
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					src_idle_pct  = 32;
					sink_idle_pct = 70;
				end
				1: begin
					src_idle_pct  = 70;
					sink_idle_pct = 32;
				end
				default: begin
					src_idle_pct  = 0;
					sink_idle_pct = 0;
				end
			endcase
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				if (phase != 1 && n == 10)
					holds_asked++;
				send_random_span();
			end
		end

		span.valid <= 1'b0;
		@(posedge clk);
		// the watchdog bounds this wait
		while (groups_pending != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
